### design/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared constants and types of the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

   localparam int VALUE_W      = 48;
   localparam int FRAC_BITS    = 16;
   localparam int INT_W        = VALUE_W - FRAC_BITS;
   localparam int MAX_DIGITS   = 9;
   localparam int BCD_DIGITS   = 10;
   localparam int BCD_W        = 4 * BCD_DIGITS;
   localparam int NDIG_W       = 4;
   localparam int CNT_W        = $clog2(INT_W);
   localparam int CHAR_W       = 8;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_INT_DIGITS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAC_DIGITS = CSR_IDX_W'(1);

   localparam logic [NDIG_W-1:0] INT_DIGITS_RESET  = NDIG_W'(5);
   localparam logic [NDIG_W-1:0] FRAC_DIGITS_RESET = NDIG_W'(2);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic                 neg;
      logic [INT_W-1:0]     ipart;
      logic [FRAC_BITS-1:0] fbits;
      logic [NDIG_W-1:0]    nint;
      logic [NDIG_W-1:0]    nfrac;
   } entry_type;

endpackage

### design/fpdf_front.sv
// ----------------------------------------------------------------------------
// fpdf_front
// Holds the digit count registers and splits an incoming word into sign,
// magnitude integer part, fraction bits and clamped digit counts.
// ----------------------------------------------------------------------------
module fpdf_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [fpdf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fpdf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [fpdf_pkg::VALUE_W-1:0]    req_value,
   output fpdf_pkg::entry_type                    entry
);
   import fpdf_pkg::*;

   logic [NDIG_W-1:0]  int_digits_ff;
   logic [NDIG_W-1:0]  frac_digits_ff;
   logic [VALUE_W-1:0] value_u;
   logic [VALUE_W-1:0] mag;
   logic               neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_digits_ff  <= INT_DIGITS_RESET;
         frac_digits_ff <= FRAC_DIGITS_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == REG_INT_DIGITS) begin
            int_digits_ff <= csr_wdata[NDIG_W-1:0];
         end else if (csr_index == REG_FRAC_DIGITS) begin
            frac_digits_ff <= csr_wdata[NDIG_W-1:0];
         end
      end
   end

   always_comb begin
      value_u = req_value;
      neg     = value_u[VALUE_W-1];
      mag     = neg ? (~value_u + VALUE_W'(1)) : value_u;

      entry.neg   = neg;
      entry.ipart = mag[VALUE_W-1:FRAC_BITS];
      entry.fbits = mag[FRAC_BITS-1:0];

      if (int_digits_ff == '0) begin
         entry.nint = NDIG_W'(1);
      end else if (int_digits_ff > NDIG_W'(MAX_DIGITS)) begin
         entry.nint = NDIG_W'(MAX_DIGITS);
      end else begin
         entry.nint = int_digits_ff;
      end

      if (frac_digits_ff > NDIG_W'(MAX_DIGITS)) begin
         entry.nfrac = NDIG_W'(MAX_DIGITS);
      end else begin
         entry.nfrac = frac_digits_ff;
      end
   end

endmodule

### design/fpdf_queue.sv
// ----------------------------------------------------------------------------
// fpdf_queue
// Short first-in first-out queue of classified words between the front
// and the back.
// ----------------------------------------------------------------------------
module fpdf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fpdf_pkg::entry_type push_entry,
   input  logic                pop,
   output fpdf_pkg::entry_type head,
   output logic                not_empty,
   output logic                full
);
   import fpdf_pkg::*;

   entry_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff;
   logic [QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/fpdf_back.sv
// ----------------------------------------------------------------------------
// fpdf_back
// Converts the integer part to BCD one bit per cycle, then emits at most one
// character per cycle: sign if negative, integer, point and fraction digits.
// ----------------------------------------------------------------------------
module fpdf_back (
   input  logic                             clock,
   input  logic                             reset,
   input  fpdf_pkg::entry_type              head,
   input  logic                             head_valid,
   output logic                             pop,
   output logic                             rsp_valid,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_char_out,
   output logic                             rsp_last
);
   import fpdf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_INT,
      ST_POINT,
      ST_FRAC
   } state_type;

   state_type            state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [NDIG_W-1:0]    nint_ff, nint_in;
   logic [NDIG_W-1:0]    nfrac_ff, nfrac_in;
   logic [INT_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 started_ff, started_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]     bcd_adj;
   logic [3:0]           int_digit;
   logic                 int_print;
   logic [FRAC_BITS+3:0] frac_x10;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;
   assign pop          = (state_ff == ST_IDLE) && head_valid;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
      int_digit = bcd_ff[{cnt_ff[3:0], 2'b00} +: 4];
      int_print = (int_digit != 4'd0) || started_ff || (cnt_ff == '0);
      frac_x10  = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      nint_in      = nint_ff;
      nfrac_in     = nfrac_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               neg_in   = head.neg;
               nint_in  = head.nint;
               nfrac_in = head.nfrac;
               bin_in   = head.ipart;
               bcd_in   = '0;
               frac_in  = head.fbits;
               cnt_in   = CNT_W'(INT_W - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[INT_W-1]};
            bin_in = {bin_ff[INT_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               cnt_in     = CNT_W'(nint_ff) - CNT_W'(1);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_INT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_MINUS;
            state_in     = ST_INT;
         end
         ST_INT: begin
            if (int_print) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + CHAR_W'(int_digit);
               rsp_last_in  = (cnt_ff == '0) && (nfrac_ff == '0);
               started_in   = 1'b1;
            end
            if (cnt_ff == '0) begin
               state_in = (nfrac_ff == '0) ? ST_IDLE : ST_POINT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_POINT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_DOT;
            cnt_in       = CNT_W'(nfrac_ff) - CNT_W'(1);
            state_in     = ST_FRAC;
         end
         ST_FRAC: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_ZERO + CHAR_W'(frac_x10[FRAC_BITS+3:FRAC_BITS]);
            rsp_last_in  = (cnt_ff == '0);
            frac_in      = frac_x10[FRAC_BITS-1:0];
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         started_ff   <= started_in;
      end
      neg_ff      <= neg_in;
      nint_ff     <= nint_in;
      nfrac_ff    <= nfrac_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      frac_ff     <= frac_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
   end

endmodule

### design/fixed_point_decimal_formatter_core.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_core
// Formats a signed fixed-point word with 16 fraction bits as decimal
// ASCII text, one character per output word, with the final one marked.
//
// Channel   Ports                                    Handshake
// input     start, busy, req_value                   start high and busy low
// output    rsp_valid, rsp_char_out, rsp_last        rsp_valid, one cycle
// config    csr_write_enable, csr_index, csr_wdata   csr_write_enable
//
// The back takes a word from the queue and runs the bit-serial BCD converter
// over the 32-bit integer part, then steps through each integer digit position
// and emits any sign, point and fraction characters.
// A two-word queue lets the front accept words while the back is working;
// busy is high while the queue is full.
// Reset is synchronous and restores five integer and two fraction digits.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [fpdf_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   output logic [fpdf_pkg::CHAR_W-1:0]         rsp_char_out,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [fpdf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpdf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fpdf_pkg::*;

   entry_type new_entry;
   entry_type head;
   logic      head_valid;
   logic      queue_full;
   logic      pop;
   logic      push;

   assign busy = queue_full;
   assign push = start && !queue_full;

   fpdf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_value        (req_value),
      .entry            (new_entry)
   );

   fpdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (new_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (head_valid),
      .full       (queue_full)
   );

   fpdf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule
